// ===== rtl/fpst_pkg.sv =====
// types and constants for the fenwick prefix sum table
package fpst_pkg;

	localparam int POS_W   = 10;
	localparam int DELTA_W = 32;
	localparam int SUM_W   = 64;

	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_WALK  = 4'b0100,
		ST_OUT   = 4'b1000
	} fpst_state_t;

endpackage

// ===== rtl/fenwick_prefix_sum_table_unit.sv =====
// fenwick prefix sum table: update walks up the tree, query walks down and sums
// walk: a walk over k nodes (k <= log2(POSITIONS)+1) reads one node ram entry a cycle;
//   an update walk is read-modify-write; a query's sum loads once the result register is free
// requests: in_stall is high outside ST_IDLE, so a new request waits until the single
//   walk through the node ram, one node per cycle, and any query output are finished
// reset: after arst_n the node ram is zeroed by a clearing pass over all POSITIONS entries,
//   during which in_stall stays high
module fenwick_prefix_sum_table_unit
	import fpst_pkg::*;
#(
	parameter int POSITIONS = 1024
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// request channel
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      op,
	input  logic [POS_W-1:0]          position,
	input  logic signed [DELTA_W-1:0] delta,
	// result channel
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [SUM_W-1:0]   prefix_sum
);

	// node k (1..POSITIONS) lives at ram address k-1
	localparam int AW = $clog2(POSITIONS);
	// node index plus one spare bit, an upward walk may step past POSITIONS
	localparam int NW = $clog2(POSITIONS + 1) + 1;
	localparam logic [AW-1:0] CLR_LAST = AW'(POSITIONS - 1);
	localparam logic [NW-1:0] IDX_MAX  = NW'(POSITIONS);

	fpst_state_t       state_q;
	logic [AW-1:0]     clr_cnt_q;
	logic              op_q;
	logic [SUM_W-1:0]  delta_q;
	logic [NW-1:0]     idx_q;
	logic [SUM_W-1:0]  acc_q;
	logic              rd_vld_s1;
	logic [AW-1:0]     addr_s1;

	logic              issue;
	logic [NW-1:0]     low_bit;
	logic [NW-1:0]     idx_next;
	logic [NW-1:0]     idx_m1;
	logic [AW-1:0]     rd_addr;
	logic [SUM_W-1:0]  rd_data;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [SUM_W-1:0]  wr_data;
	logic              out_free;
	logic              in_acc;
	logic [31:0]       pos_ext;
	logic [31:0]       qstart_ext;
	logic [31:0]       ustart_ext;
	logic              pos_in_range;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;

	// starting node: position+1, a query past the table saturates to the last node
	assign pos_ext      = 32'(position);
	assign pos_in_range = (pos_ext < 32'(POSITIONS));
	assign ustart_ext   = pos_ext + 32'd1;
	assign qstart_ext   = pos_in_range ? ustart_ext : 32'(POSITIONS);

	// walk step: lowest set bit added going up, removed going down
	always_comb begin
		low_bit  = idx_q & (~idx_q + NW'(1));
		idx_next = (op_q == OP_QUERY) ? (idx_q - low_bit) : (idx_q + low_bit);
		idx_m1   = idx_q - NW'(1);
		rd_addr  = idx_m1[AW-1:0];
		if (state_q != ST_WALK) begin
			issue = 1'b0;
		end else if (op_q == OP_QUERY) begin
			issue = (idx_q != '0);
		end else begin
			issue = (idx_q <= IDX_MAX);
		end
	end

	// write port: zeroing pass after reset, else update write-back in the cycle after the read
	always_comb begin
		if (state_q == ST_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_cnt_q;
			wr_data = '0;
		end else begin
			wr_en   = rd_vld_s1 && (op_q == OP_UPDATE);
			wr_addr = addr_s1;
			wr_data = rd_data + delta_q;
		end
	end

	fpst_ram #(
		.WIDTH (SUM_W),
		.DEPTH (POSITIONS)
	) u_node_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (issue),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
			rd_vld_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			// result register: loaded from a finished sum, emptied once taken
			if (state_q == ST_OUT && out_free) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + AW'(1);
					if (clr_cnt_q == CLR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					// an update past the table is dropped without a walk
					if (in_acc && (op == OP_QUERY || pos_in_range)) begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					// last read data consumed and nothing left to issue
					if (!issue && rd_vld_s1) begin
						state_q <= (op_q == OP_QUERY) ? ST_OUT : ST_IDLE;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		addr_s1 <= rd_addr;
		if (in_acc) begin
			op_q    <= op;
			delta_q <= {{(SUM_W - DELTA_W){delta[DELTA_W-1]}}, delta};
			acc_q   <= '0;
			idx_q   <= (op == OP_QUERY) ? qstart_ext[NW-1:0] : ustart_ext[NW-1:0];
		end else begin
			if (issue) begin
				idx_q <= idx_next;
			end
			if (rd_vld_s1 && op_q == OP_QUERY) begin
				acc_q <= acc_q + rd_data;
			end
		end
		if (state_q == ST_OUT && out_free) begin
			prefix_sum <= acc_q;
		end
	end

`ifndef SYNTHESIS
	// a query walk never writes the node ram
	a_query_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && op_q == OP_QUERY) |-> !wr_en)
		else $error("node ram written during a query walk");

	// read data only returns inside a walk
	a_read_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == ST_WALK))
		else $error("node read data outside a walk");

	// write-back and next read never hit the same node
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && issue) |-> (wr_addr != rd_addr))
		else $error("read and write of the same node in one cycle");

	// a finished sum reaches the output once the register is free
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_free) |=> (out_valid && state_q == ST_IDLE))
		else $error("query sum not presented");

	// an upward walk only reads existing nodes
	a_update_range: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && op_q == OP_UPDATE) |-> (idx_q != '0 && idx_q <= IDX_MAX))
		else $error("update walk read outside the table");
`endif

endmodule

// ===== rtl/fpst_ram.sv =====
// generic simple dual-port ram with registered read
module fpst_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
